FILE: rtl/core/act_pkg.sv
// Package: shared types, constants and the arctangent table for the tilt block
package act_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;
  localparam int ACC_FRAC        = 20;
  localparam int SQ_STEPS        = 28;
  localparam int QUEUE_DEPTH     = 2;
  localparam int RND_SH          = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic [11:0] WEIGHT_RESET = 12'd980;
  localparam logic signed [31:0] DEG90 = 32'sd90 <<< ACC_FRAC;
  localparam logic [31:0] RND_HALF = 32'd1 << (RND_SH - 1);
  localparam logic [15:0] ROLL_LIM  = 16'(180 << ANGLE_FRAC_BITS);
  localparam logic [15:0] PITCH_LIM = 16'(90 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] az;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic [22:0]        ysq;
    logic [22:0]        zsq;
    logic               wz;
  } ent_t;

  function automatic logic signed [31:0] atan_q20(input int i);
    logic signed [31:0] v;
    case (i)
      0:  v = 32'sd47185920;
      1:  v = 32'sd27855475;
      2:  v = 32'sd14718068;
      3:  v = 32'sd7471121;
      4:  v = 32'sd3750058;
      5:  v = 32'sd1876857;
      6:  v = 32'sd938658;
      7:  v = 32'sd469357;
      8:  v = 32'sd234682;
      9:  v = 32'sd117342;
      10: v = 32'sd58671;
      11: v = 32'sd29335;
      12: v = 32'sd14668;
      13: v = 32'sd7334;
      14: v = 32'sd3667;
      15: v = 32'sd1833;
      16: v = 32'sd917;
      17: v = 32'sd458;
      18: v = 32'sd229;
      19: v = 32'sd115;
      20: v = 32'sd57;
      21: v = 32'sd29;
      22: v = 32'sd14;
      23: v = 32'sd7;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/act_if.sv
// Interfaces: raw frame channel and tilt result channel
interface act_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_low_byte;
  logic [7:0] x_high_byte;
  logic [7:0] y_low_byte;
  logic [7:0] y_high_byte;
  logic [7:0] z_low_byte;
  logic [7:0] z_high_byte;
  modport source (output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                  z_low_byte, z_high_byte, input ready);
  modport sink (input valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                z_low_byte, z_high_byte, output ready);
endinterface

interface act_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] accel_x_ug;
  logic signed [23:0] accel_y_ug;
  logic signed [23:0] accel_z_ug;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  modport source (output valid, accel_x_ug, accel_y_ug, accel_z_ug, roll_angle,
                  pitch_angle, input ready);
  modport sink (input valid, accel_x_ug, accel_y_ug, accel_z_ug, roll_angle,
                pitch_angle, output ready);
endinterface

FILE: rtl/core/act_front.sv
// Front: weight register, frame unpack, axis scaling and squares
module act_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [11:0]      cfg_wdata_i,
  act_in_if.sink           in_i,
  input  logic             q_ready_i,
  output logic             push_o,
  output act_pkg::ent_t    ent_o
);
  import act_pkg::*;

  logic [11:0] weight_q, weight_d;
  logic signed [11:0] cx, cy, cz;
  logic signed [12:0] w_s;
  logic signed [24:0] px, py, pz;
  logic signed [23:0] qy, qz;

  always_comb begin
    weight_d = cfg_we_i ? cfg_wdata_i : weight_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else begin
      weight_q <= weight_d;
    end
  end

  always_comb begin
    cx  = $signed({in_i.x_high_byte, in_i.x_low_byte[7:4]});
    cy  = $signed({in_i.y_high_byte, in_i.y_low_byte[7:4]});
    cz  = $signed({in_i.z_high_byte, in_i.z_low_byte[7:4]});
    w_s = $signed({1'b0, weight_q});
    px  = cx * w_s;
    py  = cy * w_s;
    pz  = cz * w_s;
    qy  = cy * cy;
    qz  = cz * cz;
    ent_o.ax  = cx;
    ent_o.ay  = cy;
    ent_o.az  = cz;
    ent_o.sx  = px[23:0];
    ent_o.sy  = py[23:0];
    ent_o.sz  = pz[23:0];
    ent_o.ysq = qy[22:0];
    ent_o.zsq = qz[22:0];
    ent_o.wz  = (weight_q == 12'd0);
  end

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

endmodule

FILE: rtl/core/act_queue.sv
// Queue: two-entry word buffer between front and back
module act_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  act_pkg::ent_t ent_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_i,
  output act_pkg::ent_t ent_o
);
  import act_pkg::*;

  ent_t       mem_q [QUEUE_DEPTH];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign ready_o = (cnt_q != 2'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign do_pop  = pop_i && valid_o;
  assign ent_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= ent_i;
    end
  end

endmodule

FILE: rtl/core/act_back.sv
// Back: pipelined square root, two CORDIC lanes, rounding and output register
module act_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  act_pkg::ent_t ent_i,
  output logic          pop_o,
  act_out_if.source     out_o
);
  import act_pkg::*;

  typedef struct packed {
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] az;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic               wz;
    logic [23:0]        q;
    logic [31:0]        rem;
    logic [27:0]        root;
  } sq_t;

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic               zr;
    logic               zp;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] ra;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pa;
  } cd_t;

  function automatic logic [15:0] to_deg(input logic signed [31:0] acc,
                                         input logic [15:0] lim);
    logic [31:0] mag;
    logic [31:0] r;
    logic [15:0] m;
    mag = acc[31] ? 32'(-acc) : 32'(acc);
    r   = (mag + RND_HALF) >> RND_SH;
    m   = (r > {16'd0, lim}) ? lim : r[15:0];
    return acc[31] ? 16'(-m) : m;
  endfunction

  logic                  en;
  logic [SQ_STEPS:0]     sv_q;
  logic [CORDIC_STEPS:0] cv_q;
  logic                  ov_q;
  sq_t sq_q [SQ_STEPS+1];
  sq_t sq_d [SQ_STEPS+1];
  cd_t cd_q [CORDIC_STEPS+1];
  cd_t cd_d [CORDIC_STEPS+1];
  logic [15:0] roll_d, pitch_d;

  assign en    = !ov_q || out_o.ready;
  assign pop_o = en;

  always_comb begin
    sq_t s;
    logic [31:0] rn, tr;
    sq_d[0].ax   = ent_i.ax;
    sq_d[0].ay   = ent_i.ay;
    sq_d[0].az   = ent_i.az;
    sq_d[0].sx   = ent_i.sx;
    sq_d[0].sy   = ent_i.sy;
    sq_d[0].sz   = ent_i.sz;
    sq_d[0].wz   = ent_i.wz;
    sq_d[0].q    = {1'b0, ent_i.ysq} + {1'b0, ent_i.zsq};
    sq_d[0].rem  = 32'd0;
    sq_d[0].root = 28'd0;
    for (int k = 0; k < SQ_STEPS; k++) begin
      s  = sq_q[k];
      rn = {s.rem[29:0], s.q[23:22]};
      tr = {2'b00, s.root, 2'b01};
      if (rn >= tr) begin
        s.rem  = rn - tr;
        s.root = {s.root[26:0], 1'b1};
      end else begin
        s.rem  = rn;
        s.root = {s.root[26:0], 1'b0};
      end
      s.q = {s.q[21:0], 2'b00};
      sq_d[k+1] = s;
    end
  end

  always_comb begin
    sq_t t;
    cd_t c;
    logic signed [31:0] zx, zy, dx, dy;
    t    = sq_q[SQ_STEPS];
    zx   = 32'(t.az) <<< 16;
    zy   = 32'(t.ay) <<< 16;
    c.sx = t.sx;
    c.sy = t.sy;
    c.sz = t.sz;
    c.zr = t.wz || (t.ay == 12'sd0 && t.az == 12'sd0);
    c.zp = t.wz || (t.root == 28'd0 && t.ax == 12'sd0);
    if (t.az < 0) begin
      if (t.ay >= 0) begin
        c.rx = zy;
        c.ry = -zx;
        c.ra = DEG90;
      end else begin
        c.rx = -zy;
        c.ry = zx;
        c.ra = -DEG90;
      end
    end else begin
      c.rx = zx;
      c.ry = zy;
      c.ra = 32'sd0;
    end
    c.px = $signed({4'd0, t.root});
    c.py = -(32'(t.ax) <<< 16);
    c.pa = 32'sd0;
    cd_d[0] = c;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      c  = cd_q[i];
      dx = c.ry >>> i;
      dy = c.rx >>> i;
      if (c.ry >= 0) begin
        c.rx = c.rx + dx;
        c.ry = c.ry - dy;
        c.ra = c.ra + atan_q20(i);
      end else begin
        c.rx = c.rx - dx;
        c.ry = c.ry + dy;
        c.ra = c.ra - atan_q20(i);
      end
      dx = c.py >>> i;
      dy = c.px >>> i;
      if (c.py >= 0) begin
        c.px = c.px + dx;
        c.py = c.py - dy;
        c.pa = c.pa + atan_q20(i);
      end else begin
        c.px = c.px - dx;
        c.py = c.py + dy;
        c.pa = c.pa - atan_q20(i);
      end
      cd_d[i+1] = c;
    end
  end

  always_comb begin
    roll_d  = cd_q[CORDIC_STEPS].zr ? 16'd0 : to_deg(cd_q[CORDIC_STEPS].ra, ROLL_LIM);
    pitch_d = cd_q[CORDIC_STEPS].zp ? 16'd0 : to_deg(cd_q[CORDIC_STEPS].pa, PITCH_LIM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      cv_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      sv_q <= {sv_q[SQ_STEPS-1:0], valid_i};
      cv_q <= {cv_q[CORDIC_STEPS-1:0], sv_q[SQ_STEPS]};
      ov_q <= cv_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_q[k] <= sq_d[k];
      end
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        cd_q[i] <= cd_d[i];
      end
      out_o.accel_x_ug  <= cd_q[CORDIC_STEPS].sx;
      out_o.accel_y_ug  <= cd_q[CORDIC_STEPS].sy;
      out_o.accel_z_ug  <= cd_q[CORDIC_STEPS].sz;
      out_o.roll_angle  <= $signed(roll_d);
      out_o.pitch_angle <= $signed(pitch_d[14:0]);
    end
  end

  assign out_o.valid = ov_q;

endmodule

FILE: rtl/core/accel_tilt_from_raw_frame.sv
// Top level: accelerometer frame to scaled axes, roll and pitch
// Throughput: one frame per cycle; the 28-stage root pipeline and 16-stage
// CORDIC lanes advance together and stall only on a held result.
// Reset: rst_ni clears all valid bits and the queue; weight returns to 980.
module accel_tilt_from_raw_frame (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  act_in_if.sink      in_i,
  act_out_if.source   out_o
);
  import act_pkg::*;

  logic q_ready, push, q_valid, pop;
  ent_t ent_f, ent_b;

  act_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i,
    .q_ready_i(q_ready), .push_o(push), .ent_o(ent_f)
  );

  act_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .ent_i(ent_f), .ready_o(q_ready),
    .valid_o(q_valid), .pop_i(pop), .ent_o(ent_b)
  );

  act_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .ent_i(ent_b), .pop_o(pop), .out_o
  );

endmodule

FILE: rtl/core/act_checker.sv
// Checker: port-level properties of the tilt block, bound to the top level
module act_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               ready_i,
  input logic signed [23:0] ax_i,
  input logic signed [23:0] ay_i,
  input logic signed [23:0] az_i,
  input logic signed [15:0] roll_i,
  input logic signed [14:0] pitch_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(roll_i) && $stable(pitch_i))
    else $error("result changed while stalled");

  a_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> roll_i <= 16'sd23040 && roll_i >= -16'sd23040)
    else $error("roll out of range");

  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> pitch_i <= 15'sd11520 && pitch_i >= -15'sd11520)
    else $error("pitch out of range");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ax_i == 24'sd0 && ay_i == 24'sd0 && az_i == 24'sd0
    |-> roll_i == 16'sd0 && pitch_i == 15'sd0)
    else $error("zero frame gave nonzero angle");
endmodule

bind accel_tilt_from_raw_frame act_checker u_act_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(out_o.valid), .ready_i(out_o.ready),
  .ax_i(out_o.accel_x_ug), .ay_i(out_o.accel_y_ug), .az_i(out_o.accel_z_ug),
  .roll_i(out_o.roll_angle), .pitch_i(out_o.pitch_angle)
);

FILE: tb/sv/accel_tilt_from_raw_frame_tb.sv
`timescale 1ns / 1ps
// Testbench for the tilt block: random and directed frames checked against an in-bench tilt predictor
module accel_tilt_from_raw_frame_tb;
  import act_pkg::*;

  typedef struct {
    logic [7:0] xl, xh, yl, yh, zl, zh;
  } frame_t;

  typedef struct {
    logic signed [23:0] sx, sy, sz;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } tilt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic [11:0] weight = WEIGHT_RESET;

  act_in_if in_i ();
  act_out_if out_o ();

  accel_tilt_from_raw_frame dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_i.sink), .out_o(out_o.source)
  );

  always #4 clk_i = ~clk_i;

  frame_t pending_frames[$];
  tilt_t expected_tilts[$];
  int errors = 0;
  bit quiet_mode = 1'b0;
  int hold_off = 0;

  function automatic logic signed [63:0] asr64(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] cordic_deg(logic signed [63:0] x,
                                                    logic signed [63:0] y);
    logic signed [63:0] acc, t, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 64'sd90 <<< ACC_FRAC;
      end else begin
        t = x; x = -y; y = t; acc = -(64'sd90 <<< ACC_FRAC);
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; acc = acc + 64'(atan_q20(i));
      end else begin
        x = x - dx; y = y + dy; acc = acc - 64'(atan_q20(i));
      end
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] round_deg(logic signed [63:0] acc, int lim_deg);
    logic signed [63:0] mag, lim;
    mag = acc < 0 ? -acc : acc;
    lim = 64'(lim_deg) <<< ANGLE_FRAC_BITS;
    mag = (mag + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (mag > lim) mag = lim;
    return acc < 0 ? -mag : mag;
  endfunction

  function automatic logic signed [63:0] count_of(logic [7:0] lo, logic [7:0] hi);
    logic signed [11:0] c;
    c = {hi, lo[7:4]};
    return 64'(c);
  endfunction

  function automatic tilt_t predict_tilt(frame_t f, logic [11:0] w);
    tilt_t t;
    logic signed [63:0] ax, ay, az, ww, roll, pitch, r;
    ax = count_of(f.xl, f.xh);
    ay = count_of(f.yl, f.yh);
    az = count_of(f.zl, f.zh);
    ww = 64'(w);
    roll = 0;
    pitch = 0;
    if (w != 0) begin
      r = root64(64'(ay * ay + az * az) << 32);
      roll = round_deg(cordic_deg(az * 65536, ay * 65536), 180);
      pitch = round_deg(cordic_deg(r, -ax * 65536), 90);
    end
    t.sx = 24'(ax * ww);
    t.sy = 24'(ay * ww);
    t.sz = 24'(az * ww);
    t.roll = 16'(roll);
    t.pitch = 15'(pitch);
    return t;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_tilts.push_back(predict_tilt('{in_i.x_low_byte, in_i.x_high_byte,
            in_i.y_low_byte, in_i.y_high_byte, in_i.z_low_byte, in_i.z_high_byte},
            weight));
        void'(pending_frames.pop_front());
      end
      if (!(in_i.valid && !in_i.ready)) begin
        if (pending_frames.size() > (in_i.valid && in_i.ready ? 0 : 0) &&
            (quiet_mode || $urandom_range(99) >= 13) &&
            pending_frames.size() > 0) begin
          in_i.valid <= 1'b1;
          in_i.x_low_byte <= pending_frames[0].xl;
          in_i.x_high_byte <= pending_frames[0].xh;
          in_i.y_low_byte <= pending_frames[0].yl;
          in_i.y_high_byte <= pending_frames[0].yh;
          in_i.z_low_byte <= pending_frames[0].zl;
          in_i.z_high_byte <= pending_frames[0].zh;
        end else begin
          in_i.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tilt_t e;
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        if (expected_tilts.size() == 0) begin
          $error("word with no expectation");
          errors++;
        end else begin
          e = expected_tilts.pop_front();
          if (out_o.accel_x_ug !== e.sx) begin
            $error("accel_x_ug exp %0d got %0d", e.sx, out_o.accel_x_ug); errors++;
          end
          if (out_o.accel_y_ug !== e.sy) begin
            $error("accel_y_ug exp %0d got %0d", e.sy, out_o.accel_y_ug); errors++;
          end
          if (out_o.accel_z_ug !== e.sz) begin
            $error("accel_z_ug exp %0d got %0d", e.sz, out_o.accel_z_ug); errors++;
          end
          if (out_o.roll_angle !== e.roll) begin
            $error("roll_angle exp %0d got %0d", e.roll, out_o.roll_angle); errors++;
          end
          if (out_o.pitch_angle !== e.pitch) begin
            $error("pitch_angle exp %0d got %0d", e.pitch, out_o.pitch_angle); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_o.ready <= 1'b0;
      end else begin
        out_o.ready <= quiet_mode || $urandom_range(99) >= 13;
      end
    end
  end

  // the driver pops a pending frame only on accept and holds data stable while valid waits for ready
  function automatic frame_t rand_frame();
    frame_t f;
    f = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom)};
    return f;
  endfunction

  function automatic frame_t counts_frame(int x, int y, int z);
    frame_t f;
    logic [15:0] a, b, c;
    a = {12'(x), 4'($urandom)};
    b = {12'(y), 4'($urandom)};
    c = {12'(z), 4'($urandom)};
    f = '{a[7:0], a[15:8], b[7:0], b[15:8], c[7:0], c[15:8]};
    return f;
  endfunction

  task automatic drain();
    while (pending_frames.size() > 0 || expected_tilts.size() > 0 || in_i.valid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_weight(logic [11:0] w);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    weight <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int lims[5];
    lims = '{-2048, -1, 0, 1, 2047};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (lims[i]) pending_frames.push_back(counts_frame(lims[i], lims[4 - i], lims[i]));
    pending_frames.push_back(counts_frame(0, 0, 0));
    pending_frames.push_back(counts_frame(5, 0, -300));
    pending_frames.push_back(counts_frame(-5, -1, -300));
    pending_frames.push_back(counts_frame(2047, 0, 0));
    pending_frames.push_back(counts_frame(-2048, 0, 0));
    pending_frames.push_back(counts_frame(0, 1000, 0));
    pending_frames.push_back(counts_frame(0, -1000, -1));
    pending_frames.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    pending_frames.push_back('{8'h00, 8'h80, 8'h0F, 8'h7F, 8'hF0, 8'h00});
    drain();
    foreach (lims[k]) begin
      case (k)
        0: set_weight(12'd0);
        1: set_weight(12'd4095);
        2: set_weight(12'd1);
        3: set_weight(12'($urandom_range(1, 4095)));
        default: set_weight(WEIGHT_RESET);
      endcase
      if (k == 0) begin
        repeat (8) pending_frames.push_back(rand_frame());
      end else begin
        for (int n = 0; n < 240; n++) begin
          if ($urandom_range(3) == 0)
            pending_frames.push_back(rand_frame());
          else
            pending_frames.push_back(counts_frame($urandom_range(0, 40) - 20,
                $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048));
        end
        if (k == 2) hold_off = 300;
        if (k == 3) quiet_mode = 1'b1;
      end
      drain();
      quiet_mode = 1'b0;
    end
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: accel_tilt_from_raw_frame.f
rtl/core/act_pkg.sv
rtl/core/act_if.sv
rtl/core/act_front.sv
rtl/core/act_queue.sv
rtl/core/act_back.sv
rtl/core/accel_tilt_from_raw_frame.sv
rtl/core/act_checker.sv
tb/sv/accel_tilt_from_raw_frame_tb.sv
